>>> rtl/i2cs_pkg.sv
package i2cs_pkg;

    // Default width of the remaining-byte counter.
    localparam int LEN_BITS_DEFAULT = 16;

    // Most results one item can cause.
    localparam int RES_MAX = 3;

    // Reset value of the step timeout, in microseconds.
    localparam logic [15:0] TIMEOUT_RESET = 16'd5000;

    // Configuration register indexes.
    localparam logic [0:0] CFG_ENABLED = 1'b0;
    localparam logic [0:0] CFG_TIMEOUT = 1'b1;

    // Input item modes.
    localparam logic [2:0] MODE_BEGIN_WR  = 3'd0;
    localparam logic [2:0] MODE_BEGIN_RD  = 3'd1;
    localparam logic [2:0] MODE_TX_SUPPLY = 3'd2;
    localparam logic [2:0] MODE_STEP_DONE = 3'd3;
    localparam logic [2:0] MODE_TICK      = 3'd4;

    // Result kinds.
    localparam logic [1:0] KIND_BUS_CMD = 2'd0;
    localparam logic [1:0] KIND_REQ_TX  = 2'd1;
    localparam logic [1:0] KIND_RX_BYTE = 2'd2;
    localparam logic [1:0] KIND_DONE    = 2'd3;

    // Bus engine commands.
    localparam logic [2:0] CMD_START    = 3'd0;
    localparam logic [2:0] CMD_SEND     = 3'd1;
    localparam logic [2:0] CMD_RECV_ACK = 3'd2;
    localparam logic [2:0] CMD_RECV_NAK = 3'd3;
    localparam logic [2:0] CMD_STOP     = 3'd4;
    localparam logic [2:0] CMD_CLEAR    = 3'd5;

    // Error codes reported on done results.
    localparam logic [2:0] ERR_OK      = 3'd0;
    localparam logic [2:0] ERR_UNINIT  = 3'd1;
    localparam logic [2:0] ERR_TIMEOUT = 3'd2;
    localparam logic [2:0] ERR_NACK    = 3'd3;
    localparam logic [2:0] ERR_ARB     = 3'd4;
    localparam logic [2:0] ERR_UNKNOWN = 3'd5;

    // Raw bus engine status codes, after masking.
    localparam logic [7:0] STATUS_MASK     = 8'hF8;
    localparam logic [7:0] SC_START        = 8'h08;
    localparam logic [7:0] SC_RESTART      = 8'h10;
    localparam logic [7:0] SC_SLAW_ACK     = 8'h18;
    localparam logic [7:0] SC_SLAW_NACK    = 8'h20;
    localparam logic [7:0] SC_DATA_TX_ACK  = 8'h28;
    localparam logic [7:0] SC_DATA_TX_NACK = 8'h30;
    localparam logic [7:0] SC_ARB_LOST     = 8'h38;
    localparam logic [7:0] SC_SLAR_ACK     = 8'h40;
    localparam logic [7:0] SC_SLAR_NACK    = 8'h48;
    localparam logic [7:0] SC_DATA_RX_ACK  = 8'h50;
    localparam logic [7:0] SC_DATA_RX_NACK = 8'h58;

    // Decoded status classes.
    typedef enum logic [2:0] {
        ST_OK       = 3'd0,
        ST_NACK     = 3'd1,
        ST_ARB      = 3'd2,
        ST_UNKNOWN  = 3'd3,
        ST_SENTNACK = 3'd4
    } status_t;

    // Transaction phases.
    typedef enum logic [5:0] {
        PH_IDLE   = 6'b000001,
        PH_START  = 6'b000010,
        PH_ADDR   = 6'b000100,
        PH_TXNEED = 6'b001000,
        PH_TXWAIT = 6'b010000,
        PH_RXWAIT = 6'b100000
    } phase_t;

    // One result item, without its last marker.
    typedef struct packed {
        logic [1:0] kind;
        logic [2:0] bus_cmd;
        logic [7:0] bus_byte;
        logic [7:0] rx_byte;
        logic [2:0] error;
    } result_t;

    // Build a result item.
    function automatic result_t mk_result(input logic [1:0] kind, input logic [2:0] cmd,
                                          input logic [7:0] bbyte, input logic [7:0] rx,
                                          input logic [2:0] err);
        result_t r;
        r.kind     = kind;
        r.bus_cmd  = cmd;
        r.bus_byte = bbyte;
        r.rx_byte  = rx;
        r.error    = err;
        return r;
    endfunction

    // Classify a raw bus engine status.
    function automatic status_t status_decode(input logic [7:0] raw);
        status_t st;
        unique case (raw & STATUS_MASK)
            SC_START, SC_RESTART, SC_SLAW_ACK, SC_DATA_TX_ACK, SC_SLAR_ACK,
            SC_DATA_RX_ACK:                              st = ST_OK;
            SC_SLAW_NACK, SC_DATA_TX_NACK, SC_SLAR_NACK: st = ST_NACK;
            SC_ARB_LOST:                                 st = ST_ARB;
            SC_DATA_RX_NACK:                             st = ST_SENTNACK;
            default:                                     st = ST_UNKNOWN;
        endcase
        return st;
    endfunction

    // Error code for a failed step; a sent NACK outside read data is unknown.
    function automatic logic [2:0] status_to_err(input status_t st);
        logic [2:0] e;
        unique case (st)
            ST_OK:   e = ERR_OK;
            ST_NACK: e = ERR_NACK;
            ST_ARB:  e = ERR_ARB;
            default: e = ERR_UNKNOWN;
        endcase
        return e;
    endfunction

endpackage

>>> rtl/i2c_master_transaction_sequencer_core.sv
// I2C master transaction sequencer core.
// An accepted item is registered, then handled and loaded into the result queue once
// the queue has room; its results are then taken one per cycle while m_tready is high.
// Throughput: one item per cycle while each item causes at most one result and results
// are taken at once; after an item causing several results, the next item waits until
// the last of them is being taken.
// Reset: aresetn is synchronous, active low; phase goes idle, counters clear,
// enabled clears and timeout_us returns to 5000.
module i2c_master_transaction_sequencer_core #(
    parameter int LEN_BITS = i2cs_pkg::LEN_BITS_DEFAULT
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_wr_en,
    input  logic [0:0]  cfg_index,
    input  logic [15:0] cfg_wdata,
    input  logic        s_tvalid,
    output logic        s_tready,
    // slave_addr, rw_bit, length, end_with_stop, tx_byte, bus_status, bus_rx_byte, pad
    input  logic [55:0] s_tdata,
    input  logic [2:0]  s_tuser,   // mode
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,   // bus_cmd, bus_byte, rx_byte, error, pad
    output logic [1:0]  m_tuser,   // kind
    output logic        m_tlast
);

    logic        enabled_reg, enabled_next;
    logic [15:0] timeout_reg, timeout_next;

    logic        in_valid_reg, in_valid_next;
    logic [2:0]  mode_reg;
    logic [6:0]  slave_addr_reg;
    logic        rw_bit_reg;
    logic [15:0] length_reg;
    logic        end_with_stop_reg;
    logic [7:0]  tx_byte_reg;
    logic [7:0]  bus_status_reg;
    logic [7:0]  bus_rx_byte_reg;

    logic                    can_load;
    logic                    move;
    logic [1:0]              res_cnt;
    i2cs_pkg::result_t [2:0] res;

    // Configuration register writes.
    always_comb begin
        enabled_next = enabled_reg;
        timeout_next = timeout_reg;
        if (cfg_wr_en) begin
            unique case (cfg_index)
                i2cs_pkg::CFG_ENABLED: enabled_next = cfg_wdata[0];
                i2cs_pkg::CFG_TIMEOUT: timeout_next = cfg_wdata;
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            enabled_reg <= 1'b0;
            timeout_reg <= i2cs_pkg::TIMEOUT_RESET;
        end else begin
            enabled_reg <= enabled_next;
            timeout_reg <= timeout_next;
        end
    end

    // Input register: empties when its item moves into the result queue.
    assign move          = in_valid_reg && can_load;
    assign s_tready      = !in_valid_reg || move;
    assign in_valid_next = s_tready ? s_tvalid : in_valid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else begin
            in_valid_reg <= in_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            mode_reg          <= s_tuser;
            slave_addr_reg    <= s_tdata[6:0];
            rw_bit_reg        <= s_tdata[7];
            length_reg        <= s_tdata[23:8];
            end_with_stop_reg <= s_tdata[24];
            tx_byte_reg       <= s_tdata[32:25];
            bus_status_reg    <= s_tdata[40:33];
            bus_rx_byte_reg   <= s_tdata[48:41];
        end
    end

    // Transaction sequencing for the registered item.
    i2cs_seq #(
        .LEN_BITS (LEN_BITS)
    ) u_seq (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .item_valid    (move),
        .mode          (mode_reg),
        .slave_addr    (slave_addr_reg),
        .rw_bit        (rw_bit_reg),
        .length        (length_reg),
        .end_with_stop (end_with_stop_reg),
        .tx_byte       (tx_byte_reg),
        .bus_status    (bus_status_reg),
        .bus_rx_byte   (bus_rx_byte_reg),
        .enabled       (enabled_reg),
        .timeout_us    (timeout_reg),
        .res_cnt       (res_cnt),
        .res           (res)
    );

    // Result queue and output channel.
    i2cs_out_buf u_out_buf (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .load     (move),
        .load_cnt (res_cnt),
        .load_res (res),
        .can_load (can_load),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

endmodule

>>> rtl/i2cs_seq.sv
module i2cs_seq #(
    parameter int LEN_BITS = i2cs_pkg::LEN_BITS_DEFAULT
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       item_valid,
    input  logic [2:0]                 mode,
    input  logic [6:0]                 slave_addr,
    input  logic                       rw_bit,
    input  logic [15:0]                length,
    input  logic                       end_with_stop,
    input  logic [7:0]                 tx_byte,
    input  logic [7:0]                 bus_status,
    input  logic [7:0]                 bus_rx_byte,
    input  logic                       enabled,
    input  logic [15:0]                timeout_us,
    output logic [1:0]                 res_cnt,
    output i2cs_pkg::result_t [2:0]    res
);

    i2cs_pkg::phase_t     phase_reg, phase_next;
    logic                 is_read_reg, is_read_next;
    logic [LEN_BITS-1:0]  bytes_left_reg, bytes_left_next;
    logic                 stop_reg, stop_next;
    logic [15:0]          wait_reg, wait_next;
    logic [7:0]           addr_reg, addr_next;

    logic [LEN_BITS-1:0]  len_in;
    logic [LEN_BITS-1:0]  bl;
    logic                 do_adv;
    i2cs_pkg::status_t    st;
    logic [15:0]          wt;
    logic [19:0]          wt_x10;
    logic                 waiting;

    // Length sized to the counter; tick count saturates and scales by ten.
    assign len_in  = LEN_BITS'(length);
    assign st      = i2cs_pkg::status_decode(bus_status);
    assign wt      = (wait_reg != 16'hFFFF) ? wait_reg + 16'd1 : wait_reg;
    assign wt_x10  = {1'b0, wt, 3'b000} + {3'b000, wt, 1'b0};
    assign waiting = (phase_reg != i2cs_pkg::PH_IDLE) && (phase_reg != i2cs_pkg::PH_TXNEED);

    // Handle one item: next state and the results it causes.
    always_comb begin
        phase_next      = phase_reg;
        is_read_next    = is_read_reg;
        bytes_left_next = bytes_left_reg;
        stop_next       = stop_reg;
        wait_next       = wait_reg;
        addr_next       = addr_reg;
        res_cnt         = 2'd0;
        res             = '0;
        bl              = bytes_left_reg;
        do_adv          = 1'b0;
        if (item_valid) begin
            unique case (mode)
                i2cs_pkg::MODE_BEGIN_WR, i2cs_pkg::MODE_BEGIN_RD: begin
                    if (!enabled) begin
                        res[0]  = i2cs_pkg::mk_result(i2cs_pkg::KIND_DONE, i2cs_pkg::CMD_START,
                                                      8'h00, 8'h00, i2cs_pkg::ERR_UNINIT);
                        res_cnt = 2'd1;
                    end else begin
                        is_read_next    = (mode == i2cs_pkg::MODE_BEGIN_RD);
                        bytes_left_next = len_in;
                        stop_next       = end_with_stop;
                        addr_next       = {slave_addr, rw_bit};
                        wait_next       = 16'd0;
                        phase_next      = i2cs_pkg::PH_START;
                        res[0]  = i2cs_pkg::mk_result(i2cs_pkg::KIND_BUS_CMD, i2cs_pkg::CMD_START,
                                                      8'h00, 8'h00, i2cs_pkg::ERR_OK);
                        res_cnt = 2'd1;
                    end
                end
                i2cs_pkg::MODE_TX_SUPPLY: begin
                    if (phase_reg == i2cs_pkg::PH_TXNEED) begin
                        res[0]     = i2cs_pkg::mk_result(i2cs_pkg::KIND_BUS_CMD,
                                                         i2cs_pkg::CMD_SEND, tx_byte, 8'h00,
                                                         i2cs_pkg::ERR_OK);
                        res_cnt    = 2'd1;
                        wait_next  = 16'd0;
                        phase_next = i2cs_pkg::PH_TXWAIT;
                    end
                end
                i2cs_pkg::MODE_STEP_DONE: begin
                    if (waiting) begin
                        wait_next = 16'd0;
                        if (phase_reg == i2cs_pkg::PH_RXWAIT) begin
                            // Read data step.
                            if (st == i2cs_pkg::ST_OK) begin
                                res[0]  = i2cs_pkg::mk_result(i2cs_pkg::KIND_RX_BYTE,
                                                              i2cs_pkg::CMD_START, 8'h00,
                                                              bus_rx_byte, i2cs_pkg::ERR_OK);
                                res_cnt = 2'd1;
                                bl      = bytes_left_reg - LEN_BITS'(1);
                                do_adv  = 1'b1;
                            end else if (st == i2cs_pkg::ST_SENTNACK) begin
                                res[0]  = i2cs_pkg::mk_result(i2cs_pkg::KIND_RX_BYTE,
                                                              i2cs_pkg::CMD_START, 8'h00,
                                                              bus_rx_byte, i2cs_pkg::ERR_OK);
                                res[1]  = i2cs_pkg::mk_result(i2cs_pkg::KIND_BUS_CMD,
                                                              i2cs_pkg::CMD_STOP, 8'h00, 8'h00,
                                                              i2cs_pkg::ERR_OK);
                                res[2]  = i2cs_pkg::mk_result(i2cs_pkg::KIND_DONE,
                                                              i2cs_pkg::CMD_START, 8'h00, 8'h00,
                                                              i2cs_pkg::ERR_OK);
                                res_cnt    = 2'd3;
                                phase_next = i2cs_pkg::PH_IDLE;
                            end else begin
                                res[0]  = i2cs_pkg::mk_result(i2cs_pkg::KIND_BUS_CMD,
                                                              i2cs_pkg::CMD_STOP, 8'h00, 8'h00,
                                                              i2cs_pkg::ERR_OK);
                                res[1]  = i2cs_pkg::mk_result(i2cs_pkg::KIND_DONE,
                                                              i2cs_pkg::CMD_START, 8'h00, 8'h00,
                                                              i2cs_pkg::status_to_err(st));
                                res_cnt    = 2'd2;
                                phase_next = i2cs_pkg::PH_IDLE;
                            end
                        end else if (st != i2cs_pkg::ST_OK) begin
                            // Failure on start, address or written data.
                            if (st == i2cs_pkg::ST_NACK || st == i2cs_pkg::ST_ARB) begin
                                res[0]  = i2cs_pkg::mk_result(i2cs_pkg::KIND_BUS_CMD,
                                              (st == i2cs_pkg::ST_NACK) ? i2cs_pkg::CMD_STOP
                                                                        : i2cs_pkg::CMD_CLEAR,
                                              8'h00, 8'h00, i2cs_pkg::ERR_OK);
                                res[1]  = i2cs_pkg::mk_result(i2cs_pkg::KIND_DONE,
                                                              i2cs_pkg::CMD_START, 8'h00, 8'h00,
                                                              i2cs_pkg::status_to_err(st));
                                res_cnt = 2'd2;
                            end else begin
                                res[0]  = i2cs_pkg::mk_result(i2cs_pkg::KIND_DONE,
                                                              i2cs_pkg::CMD_START, 8'h00, 8'h00,
                                                              i2cs_pkg::status_to_err(st));
                                res_cnt = 2'd1;
                            end
                            phase_next = i2cs_pkg::PH_IDLE;
                        end else if (phase_reg == i2cs_pkg::PH_START) begin
                            res[0]     = i2cs_pkg::mk_result(i2cs_pkg::KIND_BUS_CMD,
                                                             i2cs_pkg::CMD_SEND, addr_reg, 8'h00,
                                                             i2cs_pkg::ERR_OK);
                            res_cnt    = 2'd1;
                            phase_next = i2cs_pkg::PH_ADDR;
                        end else if (phase_reg == i2cs_pkg::PH_ADDR) begin
                            do_adv = 1'b1;
                        end else begin
                            bl     = bytes_left_reg - LEN_BITS'(1);
                            do_adv = 1'b1;
                        end
                    end
                end
                i2cs_pkg::MODE_TICK: begin
                    if (waiting) begin
                        if (wt_x10 > {4'b0000, timeout_us}) begin
                            if (phase_reg == i2cs_pkg::PH_RXWAIT) begin
                                res[0]  = i2cs_pkg::mk_result(i2cs_pkg::KIND_BUS_CMD,
                                                              i2cs_pkg::CMD_STOP, 8'h00, 8'h00,
                                                              i2cs_pkg::ERR_OK);
                                res[1]  = i2cs_pkg::mk_result(i2cs_pkg::KIND_DONE,
                                                              i2cs_pkg::CMD_START, 8'h00, 8'h00,
                                                              i2cs_pkg::ERR_TIMEOUT);
                                res_cnt = 2'd2;
                            end else begin
                                res[0]  = i2cs_pkg::mk_result(i2cs_pkg::KIND_DONE,
                                                              i2cs_pkg::CMD_START, 8'h00, 8'h00,
                                                              i2cs_pkg::ERR_TIMEOUT);
                                res_cnt = 2'd1;
                            end
                            phase_next = i2cs_pkg::PH_IDLE;
                            wait_next  = 16'd0;
                        end else begin
                            wait_next = wt;
                        end
                    end
                end
                default: begin
                end
            endcase
        end

        // Issue the next data step, or finish when no bytes are left.
        if (do_adv) begin
            bytes_left_next = bl;
            if (is_read_reg) begin
                if (bl != '0) begin
                    res[res_cnt] = i2cs_pkg::mk_result(i2cs_pkg::KIND_BUS_CMD,
                                       (bl == LEN_BITS'(1)) ? i2cs_pkg::CMD_RECV_NAK
                                                            : i2cs_pkg::CMD_RECV_ACK,
                                       8'h00, 8'h00, i2cs_pkg::ERR_OK);
                    phase_next   = i2cs_pkg::PH_RXWAIT;
                end else begin
                    res[res_cnt] = i2cs_pkg::mk_result(i2cs_pkg::KIND_DONE, i2cs_pkg::CMD_START,
                                                       8'h00, 8'h00, i2cs_pkg::ERR_OK);
                    phase_next   = i2cs_pkg::PH_IDLE;
                end
                res_cnt = res_cnt + 2'd1;
            end else if (bl != '0) begin
                res[res_cnt] = i2cs_pkg::mk_result(i2cs_pkg::KIND_REQ_TX, i2cs_pkg::CMD_START,
                                                   8'h00, 8'h00, i2cs_pkg::ERR_OK);
                res_cnt      = res_cnt + 2'd1;
                phase_next   = i2cs_pkg::PH_TXNEED;
            end else begin
                if (stop_reg) begin
                    res[res_cnt] = i2cs_pkg::mk_result(i2cs_pkg::KIND_BUS_CMD,
                                                       i2cs_pkg::CMD_STOP, 8'h00, 8'h00,
                                                       i2cs_pkg::ERR_OK);
                    res_cnt      = res_cnt + 2'd1;
                end
                res[res_cnt] = i2cs_pkg::mk_result(i2cs_pkg::KIND_DONE, i2cs_pkg::CMD_START,
                                                   8'h00, 8'h00, i2cs_pkg::ERR_OK);
                res_cnt      = res_cnt + 2'd1;
                phase_next   = i2cs_pkg::PH_IDLE;
            end
        end
    end

    // Transaction state registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg      <= i2cs_pkg::PH_IDLE;
            is_read_reg    <= 1'b0;
            bytes_left_reg <= '0;
            stop_reg       <= 1'b0;
            wait_reg       <= 16'd0;
            addr_reg       <= 8'h00;
        end else begin
            phase_reg      <= phase_next;
            is_read_reg    <= is_read_next;
            bytes_left_reg <= bytes_left_next;
            stop_reg       <= stop_next;
            wait_reg       <= wait_next;
            addr_reg       <= addr_next;
        end
    end

endmodule

>>> rtl/i2cs_out_buf.sv
module i2cs_out_buf (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       load,
    input  logic [1:0]                 load_cnt,
    input  i2cs_pkg::result_t [2:0]    load_res,
    output logic                       can_load,
    output logic                       m_tvalid,
    input  logic                       m_tready,
    output logic [23:0]                m_tdata,   // bus_cmd, bus_byte, rx_byte, error, pad
    output logic [1:0]                 m_tuser,   // kind
    output logic                       m_tlast
);

    i2cs_pkg::result_t [2:0] res_reg, res_next;
    logic [1:0]              cnt_reg, cnt_next;
    logic                    pop;

    assign pop      = m_tvalid && m_tready;
    assign can_load = (cnt_reg == 2'd0) || ((cnt_reg == 2'd1) && m_tready);

    // Load a new group of results, or shift the queue on each output transaction.
    always_comb begin
        res_next = res_reg;
        cnt_next = cnt_reg;
        if (load) begin
            res_next = load_res;
            cnt_next = load_cnt;
        end else if (pop) begin
            res_next[0] = res_reg[1];
            res_next[1] = res_reg[2];
            cnt_next    = cnt_reg - 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= 2'd0;
        end else begin
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        res_reg <= res_next;
    end

    // Head of the queue drives the result channel.
    assign m_tvalid = (cnt_reg != 2'd0);
    assign m_tlast  = (cnt_reg == 2'd1);
    assign m_tuser  = res_reg[0].kind;
    assign m_tdata  = {2'b00, res_reg[0].error, res_reg[0].rx_byte, res_reg[0].bus_byte,
                       res_reg[0].bus_cmd};

    // A group is loaded only into an empty queue or one draining its final result.
    a_load_room: assert property (@(posedge aclk) disable iff (!aresetn)
        load |-> (cnt_reg == 2'd0 || (cnt_reg == 2'd1 && m_tready)))
        else $error("result group loaded over pending results");

    // Loading takes the group's count.
    a_load_cnt: assert property (@(posedge aclk) disable iff (!aresetn)
        load |=> (cnt_reg == $past(load_cnt)))
        else $error("result count not taken on load");

    // Each output transaction without a load removes exactly one result.
    a_drain: assert property (@(posedge aclk) disable iff (!aresetn)
        (pop && !load) |=> (cnt_reg == $past(cnt_reg) - 2'd1))
        else $error("result queue count slipped on drain");

endmodule
